// ===== rtl/eabv_pkg.sv =====
// shared types, constants and arithmetic helpers for the euler angle basis pipeline
`timescale 1ns / 1ps
package eabv_pkg;

    localparam int CordicSteps = 24;
    localparam int CW = 34;
    localparam int SC_LAT = CordicSteps + 5;
    localparam int PIPE_LAT = SC_LAT + 3;

    localparam logic [17:0] RECIP45 = 18'd186414;
    localparam int RecipShift = 23;
    localparam int Div45 = 45;
    localparam int HOffset = 4140;

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30 = 34'sd1073741824;

    typedef logic signed [31:0] q30_t;
    typedef logic [20:0] bam_tbl_t [45];
    typedef logic [29:0] atan_tbl_t [CordicSteps];

    localparam atan_tbl_t ATAN_TBL = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
        30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
        30'd652, 30'd326, 30'd163, 30'd81
    };

    // fractional part of a binary angle for each remainder of the 45 split
    function automatic bam_tbl_t build_bam_tbl();
        bam_tbl_t t;
        longint v;
        for (int i = 0; i < Div45; i++)
        begin
            v = ((longint'(i) << 21) + 64'sd22) / Div45;
            t[i] = v[20:0];
        end
        return t;
    endfunction

    localparam bam_tbl_t BAM_TBL = build_bam_tbl();

    // q2.30 product rounded half up
    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
        return p[61:30];
    endfunction

    // q4.30 to q1.15 with rounding and saturation
    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic signed [CW-16:0] r;
        s = v + 34'sd16384;
        r = s[CW-1:15];
        if (r > 19'sd32767)
        begin
            return 16'sd32767;
        end
        else if (r < -19'sd32768)
        begin
            return -16'sd32768;
        end
        return r[15:0];
    endfunction

endpackage

// ===== rtl/euler_angles_to_basis_vectors.sv =====
// top level: euler angles in degrees to forward, right and up unit vectors
`timescale 1ns / 1ps
// usage
// - input channel in_valid/in_ready carries pitch_deg, yaw_deg, roll_deg, signed
//   degrees with 8 fraction bits; a transfer happens when both are high
// - output channel out_valid/out_ready carries the nine q1.15 components of
//   the forward, right and up vectors, one result per input transfer
// - from input transfer to output valid the data passes modulo 360 reduction,
//   24 cordic iterations, 1 quadrant fix-up, 2 product stages and the output
//   register
// - throughput is one transfer per cycle while the output is not stalled; every
//   stage holds one item, set by the single-iteration cordic stages
// - when out_ready is low with a result waiting, the whole pipeline holds and
//   in_ready drops; nothing is lost or repeated
// - reset clears all valid bits; no result is presented until new input
module euler_angles_to_basis_vectors
    import eabv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] pitch_deg,
    input  logic signed [23:0] yaw_deg,
    input  logic signed [23:0] roll_deg,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] fwd_x,
    output logic signed [15:0] fwd_y,
    output logic signed [15:0] fwd_z,
    output logic signed [15:0] right_x,
    output logic signed [15:0] right_y,
    output logic signed [15:0] right_z,
    output logic signed [15:0] up_x,
    output logic signed [15:0] up_y,
    output logic signed [15:0] up_z
);

    logic en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    q30_t sp, cp, sy, cy, sr, cr;

    q30_t sp1_reg, sy1_reg, cy1_reg, sr1_reg, cr1_reg;
    q30_t spcy_reg, spsy_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg;

    q30_t fx_reg, fy_reg, fz_reg, rz_reg, uz_reg;
    q30_t a1_reg, a2_reg, b1_reg, b2_reg, c1_reg, c2_reg, d1_reg, d2_reg;

    logic signed [15:0] o_reg [9];

    assign en = !vld_reg[PIPE_LAT-1] || out_ready;
    assign in_ready = en;
    assign out_valid = vld_reg[PIPE_LAT-1];
    assign vld_next = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    eabv_sincos u_pitch (.clk(clk), .en(en), .angle(pitch_deg), .sin_q(sp), .cos_q(cp));
    eabv_sincos u_yaw   (.clk(clk), .en(en), .angle(yaw_deg),   .sin_q(sy), .cos_q(cy));
    eabv_sincos u_roll  (.clk(clk), .en(en), .angle(roll_deg),  .sin_q(sr), .cos_q(cr));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp1_reg  <= sp;
            sy1_reg  <= sy;
            cy1_reg  <= cy;
            sr1_reg  <= sr;
            cr1_reg  <= cr;
            spcy_reg <= mul30(sp, cy);
            spsy_reg <= mul30(sp, sy);
            cpcy_reg <= mul30(cp, cy);
            cpsy_reg <= mul30(cp, sy);
            srcp_reg <= mul30(sr, cp);
            crcp_reg <= mul30(cr, cp);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg <= cpcy_reg;
            fy_reg <= cpsy_reg;
            fz_reg <= -sp1_reg;
            rz_reg <= -srcp_reg;
            uz_reg <= crcp_reg;
            a1_reg <= mul30(sr1_reg, spcy_reg);
            a2_reg <= mul30(cr1_reg, sy1_reg);
            b1_reg <= mul30(sr1_reg, spsy_reg);
            b2_reg <= mul30(cr1_reg, cy1_reg);
            c1_reg <= mul30(cr1_reg, spcy_reg);
            c2_reg <= mul30(sr1_reg, sy1_reg);
            d1_reg <= mul30(cr1_reg, spsy_reg);
            d2_reg <= mul30(sr1_reg, cy1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg[0] <= to_q15(CW'(fx_reg));
            o_reg[1] <= to_q15(CW'(fy_reg));
            o_reg[2] <= to_q15(CW'(fz_reg));
            o_reg[3] <= to_q15(CW'(a2_reg) - CW'(a1_reg));
            o_reg[4] <= to_q15(-CW'(b1_reg) - CW'(b2_reg));
            o_reg[5] <= to_q15(CW'(rz_reg));
            o_reg[6] <= to_q15(CW'(c1_reg) + CW'(c2_reg));
            o_reg[7] <= to_q15(CW'(d1_reg) - CW'(d2_reg));
            o_reg[8] <= to_q15(CW'(uz_reg));
        end
    end

    assign fwd_x   = o_reg[0];
    assign fwd_y   = o_reg[1];
    assign fwd_z   = o_reg[2];
    assign right_x = o_reg[3];
    assign right_y = o_reg[4];
    assign right_z = o_reg[5];
    assign up_x    = o_reg[6];
    assign up_y    = o_reg[7];
    assign up_z    = o_reg[8];

endmodule

// ===== rtl/eabv_sincos.sv =====
// angle reduction and pipelined cordic giving sine and cosine of one angle
`timescale 1ns / 1ps
module eabv_sincos
    import eabv_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [23:0] angle,
    output q30_t               sin_q,
    output q30_t               cos_q
);

    logic [14:0] hp_wide;
    logic [13:0] hp;
    logic [31:0] prod1;
    logic [13:0] hp1_reg;
    logic [7:0]  q1_reg;
    logic [10:0] l1_reg;
    logic [13:0] hm_wide;
    logic [16:0] u2_reg;
    logic [34:0] prod3;
    logic [16:0] u3_reg;
    logic [10:0] q3_reg;
    logic [16:0] r_wide;
    logic [5:0]  r;
    logic [31:0] bam;

    logic signed [CW-1:0] x_reg [CordicSteps+1];
    logic signed [CW-1:0] y_reg [CordicSteps+1];
    logic signed [CW-1:0] z_reg [CordicSteps+1];
    logic [1:0]           quad_reg [CordicSteps+1];

    logic signed [CW-1:0] c_cl;
    logic signed [CW-1:0] s_cl;
    q30_t sin_reg;
    q30_t cos_reg;

    assign hp_wide = 15'({{2{angle[23]}}, angle[23:11]}) + 15'(HOffset);
    assign hp = hp_wide[13:0];
    assign prod1 = 32'(hp) * 32'(RECIP45);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp1_reg <= hp;
            q1_reg  <= prod1[RecipShift+7:RecipShift];
            l1_reg  <= angle[10:0];
        end
    end

    assign hm_wide = hp1_reg - 14'(q1_reg) * 14'(Div45);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u2_reg <= {hm_wide[5:0], l1_reg};
        end
    end

    assign prod3 = 35'(u2_reg) * 35'(RECIP45);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u3_reg <= u2_reg;
            q3_reg <= prod3[RecipShift+10:RecipShift];
        end
    end

    assign r_wide = u3_reg - 17'(q3_reg) * 17'(Div45);
    assign r = r_wide[5:0];
    assign bam = {q3_reg, 21'd0} + {11'd0, BAM_TBL[r]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= signed'({4'd0, bam[29:0]});
            quad_reg[0] <= bam[31:30];
        end
    end

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_cordic
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = signed'({4'd0, ATAN_TBL[i]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quad_reg[i+1] <= quad_reg[i];
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
            end
        end
    end

    always_comb
    begin
        c_cl = x_reg[CordicSteps];
        s_cl = y_reg[CordicSteps];
        if (c_cl > ONE_Q30)
        begin
            c_cl = ONE_Q30;
        end
        else if (c_cl < -ONE_Q30)
        begin
            c_cl = -ONE_Q30;
        end
        if (s_cl > ONE_Q30)
        begin
            s_cl = ONE_Q30;
        end
        else if (s_cl < -ONE_Q30)
        begin
            s_cl = -ONE_Q30;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            case (quad_reg[CordicSteps])
                2'd0:
                begin
                    sin_reg <= s_cl[31:0];
                    cos_reg <= c_cl[31:0];
                end
                2'd1:
                begin
                    sin_reg <= c_cl[31:0];
                    cos_reg <= 32'(-s_cl);
                end
                2'd2:
                begin
                    sin_reg <= 32'(-s_cl);
                    cos_reg <= 32'(-c_cl);
                end
                default:
                begin
                    sin_reg <= 32'(-c_cl);
                    cos_reg <= s_cl[31:0];
                end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== verif/euler_angles_to_basis_vectors_tb.sv =====
// testbench: euler angles to basis vectors against a bit-accurate cordic predictor
`timescale 1ns / 1ps
module euler_angles_to_basis_vectors_tb;

    localparam int TurnUnits = 92160;
    localparam int Steps = 24;
    localparam longint Gain = 64'sd652032874;
    localparam longint OneQ30 = 64'sd1073741824;
    localparam int WatchdogLimit = 20000;

    typedef struct packed {
        logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
    } basis_t;

    typedef struct {
        logic signed [23:0] p, y, r;
        logic               known;
        basis_t             res;
    } angle_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] pitch_deg;
    logic signed [23:0] yaw_deg;
    logic signed [23:0] roll_deg;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] fwd_x, fwd_y, fwd_z;
    logic signed [15:0] right_x, right_y, right_z;
    logic signed [15:0] up_x, up_y, up_z;

    basis_t     pending_basis[$];
    angle_row_t angle_rows[$];
    int         errors;
    int         idle_cycles;
    logic       stall_hold;
    logic       rx_steady;
    logic       stim_done;

    longint atan_units[Steps] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    euler_angles_to_basis_vectors i_dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint clamp_one(input longint v);
        if (v > OneQ30)
        begin
            return OneQ30;
        end
        if (v < -OneQ30)
        begin
            return -OneQ30;
        end
        return v;
    endfunction

    function automatic void angle_sin_cos(input logic signed [23:0] deg, output longint s,
                                          output longint c);
        longint a, bam, x, yv, z, nx, dx, dy, cs, sn;
        int quad;
        a = longint'(deg) % TurnUnits;
        if (a < 0)
        begin
            a += TurnUnits;
        end
        bam = ((a << 21) + 22) / 45;
        quad = int'((bam >> 30) & 3);
        z = bam & 64'h3FFF_FFFF;
        x = Gain;
        yv = 0;
        for (int i = 0; i < Steps; i++)
        begin
            dx = yv >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                nx = x - dx;
                yv = yv + dy;
                z -= atan_units[i];
            end
            else
            begin
                nx = x + dx;
                yv = yv - dy;
                z += atan_units[i];
            end
            x = nx;
        end
        cs = clamp_one(x);
        sn = clamp_one(yv);
        case (quad)
            0:
            begin
                s = sn;
                c = cs;
            end
            1:
            begin
                s = cs;
                c = -sn;
            end
            2:
            begin
                s = -sn;
                c = -cs;
            end
            default:
            begin
                s = -cs;
                c = sn;
            end
        endcase
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic basis_t basis_of(input logic signed [23:0] p,
                                        input logic signed [23:0] y,
                                        input logic signed [23:0] r);
        longint sp, cp, sy, cy, sr, cr, spcy, spsy;
        basis_t b;
        angle_sin_cos(p, sp, cp);
        angle_sin_cos(y, sy, cy);
        angle_sin_cos(r, sr, cr);
        spcy = fix_mul(sp, cy);
        spsy = fix_mul(sp, sy);
        b.fx = round_q15(fix_mul(cp, cy));
        b.fy = round_q15(fix_mul(cp, sy));
        b.fz = round_q15(-sp);
        b.rx = round_q15(-fix_mul(sr, spcy) + fix_mul(cr, sy));
        b.ry = round_q15(-fix_mul(sr, spsy) - fix_mul(cr, cy));
        b.rz = round_q15(-fix_mul(sr, cp));
        b.ux = round_q15(fix_mul(cr, spcy) + fix_mul(sr, sy));
        b.uy = round_q15(fix_mul(cr, spsy) - fix_mul(sr, cy));
        b.uz = round_q15(fix_mul(cr, cp));
        return b;
    endfunction

    function automatic logic signed [23:0] random_angle();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 46080)) - 24'sd23040;
            2: return 24'(int'($urandom_range(0, 16)) * 5760 - 46080);
            3: return 24'(int'($urandom_range(0, 90)) * 92160 +
                          int'($urandom_range(0, 2)) - 1);
            4: return $urandom_range(0, 1) ? 24'sh7FFFFF - 24'($urandom_range(0, 3))
                                           : 24'sh800000 + 24'($urandom_range(0, 3));
            default: return 24'($urandom_range(0, 92159));
        endcase
    endfunction

    function automatic angle_row_t row(input int p, input int y, input int r);
        angle_row_t t;
        t.p = 24'(p);
        t.y = 24'(y);
        t.r = 24'(r);
        t.known = 1'b0;
        return t;
    endfunction

    task automatic send_angles(input angle_row_t t, input bit allow_idle);
        if (allow_idle)
        begin
            while ($urandom_range(0, 99) < 6)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        pitch_deg <= t.p;
        yaw_deg <= t.y;
        roll_deg <= t.r;
        pending_basis.push_back(t.known ? t.res : basis_of(t.p, t.y, t.r));
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic signed [15:0] exp_v,
                               input logic signed [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // directed angle rows; zero angles give the identity frame with the right vector pointing to -y
    initial
    begin
        angle_row_t t;
        t = row(0, 0, 0);
        t.known = 1'b1;
        t.res = '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0,
                  16'sd0, 16'sd0, 16'sd32767};
        angle_rows.push_back(t);
        t = row(90 * 256, 0, 0);
        t.known = 1'b1;
        t.res = '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0,
                  16'sd32767, 16'sd0, 16'sd0};
        angle_rows.push_back(t);
        angle_rows.push_back(row(0, 90 * 256, 0));
        angle_rows.push_back(row(0, 0, 90 * 256));
        angle_rows.push_back(row(180 * 256, 180 * 256, 180 * 256));
        angle_rows.push_back(row(270 * 256, 270 * 256, 270 * 256));
        angle_rows.push_back(row(360 * 256, -360 * 256, 720 * 256));
        angle_rows.push_back(row(-90 * 256, -180 * 256, -270 * 256));
        angle_rows.push_back(row(8388607, 8388607, 8388607));
        angle_rows.push_back(row(-8388608, -8388608, -8388608));
        angle_rows.push_back(row(92159, 1, -1));
        angle_rows.push_back(row(45 * 256, 30 * 256, 60 * 256));
        angle_rows.push_back(row(23039, 23041, 46079));
        angle_rows.push_back(row(-23040, 69120, 46081));
        angle_rows.push_back(row(1, 2, 3));
        angle_rows.push_back(row(-8388608, 8388607, 0));
    end

    initial
    begin
        errors = 0;
        stim_done = 1'b0;
        stall_hold = 1'b0;
        rx_steady = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pitch_deg = '0;
        yaw_deg = '0;
        roll_deg = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (angle_rows[i])
        begin
            send_angles(angle_rows[i], 1'b1);
        end
        in_valid <= 1'b0;
        // sender pause until the pipeline drains
        while (pending_basis.size() != 0)
        begin
            @(posedge clk);
        end
        for (int n = 0; n < 1450; n++)
        begin
            angle_row_t t;
            t = row(int'(random_angle()), int'(random_angle()), int'(random_angle()));
            if (n == 200)
            begin
                stall_hold <= 1'b1;
            end
            if (n == 600)
            begin
                rx_steady <= 1'b1;
            end
            if (n == 900)
            begin
                rx_steady <= 1'b0;
            end
            send_angles(t, !(n >= 600 && n < 900));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off and a window of steady ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            idle_cycles <= 0;
        end
        else if (stall_hold && idle_cycles < 200)
        begin
            out_ready <= 1'b0;
            idle_cycles <= idle_cycles + 1;
        end
        else if (rx_steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= $urandom_range(0, 99) >= 6;
        end
    end

    always @(posedge clk)
    begin
        basis_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_basis.size() == 0)
            begin
                $error("transfer with no expected result");
                errors++;
            end
            else
            begin
                e = pending_basis.pop_front();
                check_field("fwd_x", e.fx, fwd_x);
                check_field("fwd_y", e.fy, fwd_y);
                check_field("fwd_z", e.fz, fwd_z);
                check_field("right_x", e.rx, right_x);
                check_field("right_y", e.ry, right_y);
                check_field("right_z", e.rz, right_z);
                check_field("up_x", e.ux, up_x);
                check_field("up_y", e.uy, up_y);
                check_field("up_z", e.uz, up_z);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (!(stim_done && pending_basis.size() == 0) && quiet < WatchdogLimit)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        if (quiet >= WatchdogLimit)
        begin
            $display("Verification failed");
        end
        else
        begin
            repeat (40) @(posedge clk);
            if (errors == 0 && pending_basis.size() == 0)
            begin
                $display("Verification passed");
            end
            else
            begin
                $display("Verification failed");
            end
        end
        $finish;
    end

endmodule
